FILE: sv/fcd_pkg.sv
// fcd_pkg: shared widths, register codes and the configuration struct of the
// force contact detector; no dependencies
package fcd_pkg;

    localparam int ADC_W      = 10;
    localparam int RAW_W      = 8;
    localparam int AVG_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int GAIN_W     = 16;
    localparam int CNT_W      = 8;
    localparam int LEVEL_W    = 8;
    localparam int OPA_W      = 26;
    localparam int OPB_W      = 18;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_MARGIN    = 3'd1,
        REG_WEIGHT    = 3'd2,
        REG_GAIN      = 3'd3,
        REG_SETTLE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  threshold;
        logic [LEVEL_W-1:0]  margin;
        logic [WEIGHT_W-1:0] weight;
        logic [GAIN_W-1:0]   gain;
        logic [CNT_W-1:0]    settle;
    } cfg_t;

endpackage

FILE: sv/fcd_cfg.sv
// fcd_cfg: configuration register file written through the plain write port
// depends on fcd_pkg
module fcd_cfg
    import fcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= LEVEL_W'(128);
            cfg_reg.margin    <= LEVEL_W'(8);
            cfg_reg.weight    <= WEIGHT_W'(16384);
            cfg_reg.gain      <= GAIN_W'(256);
            cfg_reg.settle    <= CNT_W'(3);
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata[LEVEL_W-1:0];
                REG_MARGIN:    cfg_reg.margin    <= cfg_wdata[LEVEL_W-1:0];
                REG_WEIGHT:    cfg_reg.weight    <= cfg_wdata[WEIGHT_W-1:0];
                REG_GAIN:      cfg_reg.gain      <= cfg_wdata[GAIN_W-1:0];
                REG_SETTLE:    cfg_reg.settle    <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/fcd_mul.sv
// fcd_mul: shared signed multiplier with a registered product
// depends on fcd_pkg
module fcd_mul
    import fcd_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: sv/fcd_debounce.sv
// fcd_debounce: hysteresis band decision and settle counter for the contact flag
// depends on fcd_pkg
module fcd_debounce
    import fcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic [LEVEL_W-1:0] level,
    input  logic               commit,
    output logic               contact
);

    logic             contact_reg, contact_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;
    logic [LEVEL_W:0] band_hi;
    logic signed [LEVEL_W+1:0] band_lo;
    logic signed [LEVEL_W+1:0] level_s;
    logic             proposal;

    always_comb begin
        band_hi  = {1'b0, cfg.threshold} + {1'b0, cfg.margin};
        band_lo  = $signed({2'b00, cfg.threshold}) - $signed({2'b00, cfg.margin});
        level_s  = $signed({2'b00, level});
        proposal = contact_reg;
        if ({1'b0, level} > band_hi) begin
            proposal = 1'b1;
        end else if (level_s < band_lo) begin
            proposal = 1'b0;
        end
        count_inc    = count_reg + CNT_W'(1);
        contact_next = contact_reg;
        count_next   = '0;
        if (proposal != contact_reg) begin
            if (count_inc >= cfg.settle) begin
                contact_next = proposal;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_reg <= 1'b0;
            count_reg   <= '0;
        end else if (commit) begin
            contact_reg <= contact_next;
            count_reg   <= count_next;
        end
    end

    assign contact = contact_next;

endmodule

FILE: sv/force_contact_detector.sv
// Force contact detector: each input beat carries one 10-bit sensor sample and
// yields one output beat with the filtered force level and the debounced
// contact flag. An accepted sample passes the states S_DELTA, S_ACC, S_GAIN
// and S_OUT (only S_GAIN and S_OUT for the first sample after reset, which
// seeds the average): one multiplier is shared by the average update and the
// gain, and each of its two products is registered before it is used. The
// input is ready only while no sample is in flight; a finished result waits
// in an output register, so the next sample is taken even if that result
// has not yet been taken.
// Registers may be written only while no sample is in flight.
// depends on fcd_pkg, fcd_cfg, fcd_mul, fcd_debounce
module force_contact_detector
    import fcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [7:0] force_level, [8] in_contact
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_ACC,
        S_GAIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    cfg_t cfg;
    logic [RAW_W-1:0]  raw_reg;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic              seeded_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic signed [OPA_W-1:0]  op_a, delta;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod, step_sum, step;
    logic [WEIGHT_W-1:0]      weight_eff;
    logic [RAW_W-1:0]         raw_in;
    logic [39:0]              gained, gained_rnd;
    logic [LEVEL_W-1:0]       level;
    logic                     out_free, accept, commit, contact;

    localparam logic [39:0] LEVEL_CAP = {LEVEL_MAX, 32'd0} >> 8;
    localparam logic [39:0] ROUND_HALF = 40'd1 << 23;

    fcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fcd_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    fcd_debounce u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .level   (level),
        .commit  (commit),
        .contact (contact)
    );

    always_comb begin
        raw_in     = s_tdata[ADC_W-1:ADC_W-RAW_W];
        weight_eff = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
        delta      = $signed({2'b00, raw_reg, FRAC_W'(0)}) - $signed({2'b00, avg_reg});
        if (state_reg == S_DELTA) begin
            op_a = delta;
            op_b = $signed({1'b0, weight_eff});
        end else begin
            op_a = $signed({2'b00, avg_reg});
            op_b = $signed({2'b00, cfg.gain});
        end
        // rounded step of the moving average
        step_sum = prod + PROD_W'(1 << (FRAC_W - 1));
        step     = step_sum >>> FRAC_W;
        avg_next = avg_reg + step[AVG_W-1:0];

        gained     = prod[39:0];
        gained_rnd = gained + ROUND_HALF;
        level      = (gained > LEVEL_CAP) ? LEVEL_MAX : gained_rnd[31:24];

        out_free = !m_tvalid_reg || m_tready;
        accept   = (state_reg == S_IDLE) && s_tvalid;
        commit   = (state_reg == S_OUT) && out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = seeded_reg ? S_DELTA : S_GAIN;
            S_DELTA: state_next = S_ACC;
            S_ACC:   state_next = S_GAIN;
            S_GAIN:  state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            seeded_reg   <= 1'b0;
            avg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                raw_reg <= raw_in;
                if (!seeded_reg) begin
                    avg_reg    <= {raw_in, FRAC_W'(0)};
                    seeded_reg <= 1'b1;
                end
            end
            if (state_reg == S_ACC) begin
                avg_reg <= avg_next;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {(M_TDATA_W - LEVEL_W - 1)'(0), contact, level};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
